/* src/eir_pkg.sv */
// ----------------------------------------------------------------------------
// eir_pkg: shared types and codes for the entity ID registry
// Beat layouts, operation and status codes, search-token flags and the
// controller state type.
// ----------------------------------------------------------------------------
package eir_pkg;

  // Fixed field widths of the beats
  localparam int ID_FIELD_W    = 32;
  localparam int COUNT_FIELD_W = 7;
  localparam int CODE_W        = 3;

  // Operation codes
  localparam logic [CODE_W-1:0] OP_CREATE    = 3'd0;
  localparam logic [CODE_W-1:0] OP_CREATE_ID = 3'd1;
  localparam logic [CODE_W-1:0] OP_DESTROY   = 3'd2;
  localparam logic [CODE_W-1:0] OP_ALIVE     = 3'd3;
  localparam logic [CODE_W-1:0] OP_CLEAR     = 3'd4;

  // Status codes
  localparam logic [CODE_W-1:0] ST_OK        = 3'd0;
  localparam logic [CODE_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [CODE_W-1:0] ST_ALIVE     = 3'd2;
  localparam logic [CODE_W-1:0] ST_FULL      = 3'd3;
  localparam logic [CODE_W-1:0] ST_EXHAUSTED = 3'd4;

  // Request beat
  typedef struct packed {
    logic [CODE_W-1:0]     op;
    logic [ID_FIELD_W-1:0] entity_id;
  } in_beat_t;

  // Response beat
  typedef struct packed {
    logic [ID_FIELD_W-1:0]    result_id;
    logic                     ok;
    logic [CODE_W-1:0]        status;
    logic [COUNT_FIELD_W-1:0] live_count;
  } out_beat_t;

  // Flags of the search token walking the cell row
  typedef struct packed {
    logic vld;    // token present in this stage
    logic del;    // destroy: matching cell takes the last entry
    logic found;  // a match has been seen upstream
  } tok_t;

  // Controller states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_RESP
  } fsm_t;

endpackage

/* src/eir_cell.sv */
// ----------------------------------------------------------------------------
// eir_cell: one slot of the live ID table
// Holds one entry, compares it against the broadcast query as the search
// token passes, picks up the last live entry and performs swap-remove.
// ----------------------------------------------------------------------------
module eir_cell #(
  parameter int IDX     = 0,
  parameter int ENTRY_W = 32,
  parameter int CNT_W   = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  eir_pkg::tok_t      tok_i,
  input  logic [ENTRY_W-1:0] last_i,
  output eir_pkg::tok_t      tok_o,
  output logic [ENTRY_W-1:0] last_o,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [ENTRY_W-1:0] qid_i,
  input  logic               wr_en_i,
  input  logic [ENTRY_W-1:0] wr_data_i
);

  logic [ENTRY_W-1:0] entry_r, entry_nxt;
  eir_pkg::tok_t      tok_r, tok_nxt;
  logic [ENTRY_W-1:0] last_r, last_nxt;
  logic               active, is_last, hit;

  // Slot position against the live count
  assign active  = CNT_W'(IDX) < count_i;
  assign is_last = CNT_W'(IDX + 1) == count_i;
  assign hit     = tok_i.vld && active && (entry_r == qid_i);

  // Token update and entry write
  always_comb begin
    tok_nxt       = tok_i;
    tok_nxt.found = tok_i.found | hit;
    last_nxt      = (tok_i.vld && is_last) ? entry_r : last_i;
    entry_nxt     = entry_r;
    if (wr_en_i && (CNT_W'(IDX) == count_i)) begin
      entry_nxt = wr_data_i;
    end else if (tok_i.del && hit && !is_last) begin
      // last entry was captured further up the row
      entry_nxt = last_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    last_r  <= last_nxt;
  end

  assign tok_o  = tok_r;
  assign last_o = last_r;

endmodule

/* src/entity_id_registry.sv */
// ----------------------------------------------------------------------------
// entity_id_registry: dense set of live entity IDs with swap-remove
// Top level: request/response control and the row of table cells.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one response beat.
// Create, clear, unknown codes and create-with-id of a zero or out-of-range
// ID load the response directly; it is offered in the cycle after the
// request is taken. Destroy, is-alive and a valid create-with-id send a
// search token along the row of CAPACITY cells, one cell per cycle, and the
// response is offered once the token has left slot 0. The next request is
// taken once the response beat has been accepted. The table needs no clearing
// pass after reset: slots at or beyond the live count are never looked at.
// ----------------------------------------------------------------------------
module entity_id_registry #(
  parameter int CAPACITY = 64,
  parameter int ID_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  eir_pkg::in_beat_t    in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output eir_pkg::out_beat_t   out_beat
);

  localparam int ENTRY_W = (ID_BITS < eir_pkg::ID_FIELD_W) ? ID_BITS : eir_pkg::ID_FIELD_W;
  localparam int NFID_W  = ENTRY_W + 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  eir_pkg::fsm_t               state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [NFID_W-1:0]           nfid_r, nfid_nxt;
  logic [eir_pkg::CODE_W-1:0]  op_r;
  logic [ENTRY_W-1:0]          id_r;
  logic                        id_oor_r;
  eir_pkg::tok_t               launch_r, launch_nxt;
  eir_pkg::out_beat_t          res_r, res_nxt;
  logic                        res_load;
  logic                        in_fire, full, id_oor, found;
  logic                        wr_en;
  logic [ENTRY_W-1:0]          wr_data;
  eir_pkg::tok_t               tok_w  [CAPACITY+1];
  logic [ENTRY_W-1:0]          last_w [CAPACITY+1];

  assign in_fire = in_valid && !in_stall;
  assign full    = count_r == CNT_W'(CAPACITY);
  assign id_oor  = (in_beat.entity_id >> ENTRY_W) != '0;
  assign found   = tok_w[0].found && !id_oor_r;

  // Request decode, search completion and table updates
  always_comb begin
    count_nxt  = count_r;
    nfid_nxt   = nfid_r;
    wr_en      = 1'b0;
    wr_data    = id_r;
    launch_nxt = '0;
    res_load   = 1'b0;
    res_nxt    = '0;
    res_nxt.status = eir_pkg::ST_NOT_FOUND;
    if (state_r == eir_pkg::FSM_IDLE && in_fire) begin
      unique case (in_beat.op)
        eir_pkg::OP_CREATE: begin
          res_load = 1'b1;
          if (full) begin
            res_nxt.status = eir_pkg::ST_FULL;
          end else if (nfid_r[ENTRY_W]) begin
            res_nxt.status = eir_pkg::ST_EXHAUSTED;
          end else begin
            wr_en             = 1'b1;
            wr_data           = nfid_r[ENTRY_W-1:0];
            count_nxt         = count_r + 1'b1;
            nfid_nxt          = nfid_r + 1'b1;
            res_nxt.result_id = eir_pkg::ID_FIELD_W'(nfid_r[ENTRY_W-1:0]);
            res_nxt.ok        = 1'b1;
            res_nxt.status    = eir_pkg::ST_OK;
          end
        end
        eir_pkg::OP_CREATE_ID: begin
          if (in_beat.entity_id == '0 || id_oor) begin
            res_load = 1'b1;
          end else begin
            launch_nxt.vld = 1'b1;
          end
        end
        eir_pkg::OP_DESTROY: begin
          // an out-of-range ID only aliases a stored one, so it never swaps
          launch_nxt.vld = 1'b1;
          launch_nxt.del = !id_oor;
        end
        eir_pkg::OP_ALIVE: begin
          launch_nxt.vld = 1'b1;
        end
        eir_pkg::OP_CLEAR: begin
          res_load       = 1'b1;
          count_nxt      = '0;
          nfid_nxt       = NFID_W'(1);
          res_nxt.ok     = 1'b1;
          res_nxt.status = eir_pkg::ST_OK;
        end
        default: begin
          res_load = 1'b1;
        end
      endcase
    end else if (state_r == eir_pkg::FSM_SCAN && tok_w[0].vld) begin
      res_load = 1'b1;
      unique case (op_r)
        eir_pkg::OP_CREATE_ID: begin
          if (found) begin
            res_nxt.status = eir_pkg::ST_ALIVE;
          end else if (full) begin
            res_nxt.status = eir_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_data   = id_r;
            count_nxt = count_r + 1'b1;
            if ({1'b0, id_r} >= nfid_r) begin
              nfid_nxt = {1'b0, id_r} + 1'b1;
            end
            res_nxt.result_id = eir_pkg::ID_FIELD_W'(id_r);
            res_nxt.ok        = 1'b1;
            res_nxt.status    = eir_pkg::ST_OK;
          end
        end
        eir_pkg::OP_DESTROY: begin
          if (found) begin
            count_nxt         = count_r - 1'b1;
            res_nxt.result_id = eir_pkg::ID_FIELD_W'(id_r);
            res_nxt.ok        = 1'b1;
            res_nxt.status    = eir_pkg::ST_OK;
          end
        end
        default: begin
          if (found) begin
            res_nxt.result_id = eir_pkg::ID_FIELD_W'(id_r);
            res_nxt.ok        = 1'b1;
            res_nxt.status    = eir_pkg::ST_OK;
          end
        end
      endcase
    end
    res_nxt.live_count = eir_pkg::COUNT_FIELD_W'(count_nxt);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      eir_pkg::FSM_IDLE: begin
        if (in_fire) begin
          state_nxt = res_load ? eir_pkg::FSM_RESP : eir_pkg::FSM_SCAN;
        end
      end
      eir_pkg::FSM_SCAN: begin
        if (tok_w[0].vld) begin
          state_nxt = eir_pkg::FSM_RESP;
        end
      end
      eir_pkg::FSM_RESP: begin
        if (!out_stall) begin
          state_nxt = eir_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = eir_pkg::FSM_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = state_r != eir_pkg::FSM_IDLE;
    out_valid = state_r == eir_pkg::FSM_RESP;
    out_beat  = res_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= eir_pkg::FSM_IDLE;
      count_r  <= '0;
      nfid_r   <= NFID_W'(1);
      launch_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      nfid_r   <= nfid_nxt;
      launch_r <= launch_nxt;
    end
  end

  // Request and response payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_beat.op;
      id_r     <= in_beat.entity_id[ENTRY_W-1:0];
      id_oor_r <= id_oor;
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  // Cell row: token enters at the top slot and walks down to slot 0
  assign tok_w[CAPACITY]  = launch_r;
  assign last_w[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    eir_cell #(
      .IDX     (g),
      .ENTRY_W (ENTRY_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (tok_w[g+1]),
      .last_i    (last_w[g+1]),
      .tok_o     (tok_w[g]),
      .last_o    (last_w[g]),
      .count_i   (count_r),
      .qid_i     (id_r),
      .wr_en_i   (wr_en),
      .wr_data_i (wr_data)
    );
  end

endmodule

/* src/eir_checker.sv */
// ----------------------------------------------------------------------------
// eir_checker: port-level checks for the entity ID registry
// Watches the request and response channels and flags broken behaviour.
// ----------------------------------------------------------------------------
module eir_checker #(
  parameter int CAPACITY = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input eir_pkg::out_beat_t out_beat
);

  // A stalled response beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("response beat changed while stalled");

  // ok and status agree
  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.ok == (out_beat.status == eir_pkg::ST_OK)))
    else $error("ok flag disagrees with status");

  // Failures carry no ID
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.ok |-> out_beat.result_id == '0)
    else $error("failed operation returned a non-zero ID");

  // Live count never exceeds the table size
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_beat.live_count) <= 32'(CAPACITY))
    else $error("live count above capacity");

  // One request in flight: the request side stalls after each accepted beat
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

endmodule

bind entity_id_registry eir_checker #(
  .CAPACITY (CAPACITY)
) u_eir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
